>>> hdl/tca_pkg.sv
// Shared types and constants for the tiny CPU ALU.
// Holds mode codes, sequencer state enums and the structs between
// the controller and the arithmetic unit. No dependencies.
`timescale 1ns / 1ps

package tca_pkg;

   localparam int DATA_W    = 8;
   localparam int RF_DEPTH  = 16;
   localparam int RF_ADDR_W = 4;
   localparam int EXP_W     = 4;
   localparam int MAG_W     = 5;

   // instruction modes
   localparam logic [1:0] MODE_INT   = 2'd0;
   localparam logic [1:0] MODE_FLOAT = 2'd1;
   localparam logic [1:0] MODE_LOAD  = 2'd2;

   // controller sequencer
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_RD_A,
      ST_RD_B,
      ST_EXEC,
      ST_WAIT,
      ST_WRITE
   } ctl_state_type;

   // arithmetic unit sequencer
   typedef enum logic [2:0] {
      EX_IDLE,
      EX_ALIGN,
      EX_ADD,
      EX_NORM,
      EX_DONE
   } exec_state_type;

   typedef struct packed {
      logic              start;
      logic              is_float;
      logic [DATA_W-1:0] op_a;
      logic [DATA_W-1:0] op_b;
   } exec_req_type;

   typedef struct packed {
      logic              done;
      logic [DATA_W-1:0] value;
      logic              wrapped;
   } exec_rsp_type;

endpackage

>>> hdl/tca_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Width and depth come from parameters. No dependencies.
`timescale 1ns / 1ps

module tca_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hdl/tca_exec.sv
// Iterative arithmetic unit: one shared 8-bit adder serves the integer add
// and the mantissa add; float alignment and normalization step per cycle.
// Depends on tca_pkg.
`timescale 1ns / 1ps

module tca_exec (
   input  logic                  clock,
   input  logic                  reset,
   input  tca_pkg::exec_req_type ex_req,
   output tca_pkg::exec_rsp_type ex_rsp
);

   tca_pkg::exec_state_type state_ff, state_in;

   logic                         is_float_ff, is_float_in;
   logic [tca_pkg::DATA_W-1:0]   opnd_a_ff, opnd_a_in;
   logic [tca_pkg::DATA_W-1:0]   opnd_b_ff, opnd_b_in;
   logic [tca_pkg::EXP_W-1:0]    exp_ff, exp_in;
   logic                         neg_ff, neg_in;
   logic [tca_pkg::MAG_W-1:0]    mag_ff, mag_in;
   logic [tca_pkg::DATA_W-1:0]   res_ff, res_in;
   logic                         wrap_ff, wrap_in;

   logic [tca_pkg::DATA_W-1:0]   sum;
   logic [2:0]                   fa, fb;
   logic [3:0]                   ma, mb;

   // shared adder
   assign sum = opnd_a_ff + opnd_b_ff;
   assign fa  = opnd_a_ff[6:4];
   assign fb  = opnd_b_ff[6:4];

   // hold state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tca_pkg::EX_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      is_float_ff <= is_float_in;
      opnd_a_ff   <= opnd_a_in;
      opnd_b_ff   <= opnd_b_in;
      exp_ff      <= exp_in;
      neg_ff      <= neg_in;
      mag_ff      <= mag_in;
      res_ff      <= res_in;
      wrap_ff     <= wrap_in;
   end

   // sequence one operation
   always_comb begin
      state_in    = state_ff;
      is_float_in = is_float_ff;
      opnd_a_in   = opnd_a_ff;
      opnd_b_in   = opnd_b_ff;
      exp_in      = exp_ff;
      neg_in      = neg_ff;
      mag_in      = mag_ff;
      res_in      = res_ff;
      wrap_in     = wrap_ff;
      ma          = opnd_a_ff[3:0];
      mb          = opnd_b_ff[3:0];
      ex_rsp.done    = 1'b0;
      ex_rsp.value   = res_ff;
      ex_rsp.wrapped = wrap_ff;

      case (state_ff)
         tca_pkg::EX_IDLE: begin
            if (ex_req.start) begin
               opnd_a_in   = ex_req.op_a;
               opnd_b_in   = ex_req.op_b;
               is_float_in = ex_req.is_float;
               state_in    = ex_req.is_float ? tca_pkg::EX_ALIGN : tca_pkg::EX_ADD;
            end
         end
         tca_pkg::EX_ALIGN: begin
            // shift the smaller-exponent mantissa right, keep the larger exponent
            if (fa > fb) begin
               mb     = opnd_b_ff[3:0] >> (fa - fb);
               exp_in = {1'b0, fa};
            end else begin
               ma     = opnd_a_ff[3:0] >> (fb - fa);
               exp_in = {1'b0, fb};
            end
            // apply signs for the adder
            opnd_a_in = opnd_a_ff[7] ? (8'd0 - {4'd0, ma}) : {4'd0, ma};
            opnd_b_in = opnd_b_ff[7] ? (8'd0 - {4'd0, mb}) : {4'd0, mb};
            state_in  = tca_pkg::EX_ADD;
         end
         tca_pkg::EX_ADD: begin
            if (is_float_ff) begin
               neg_in   = sum[7];
               mag_in   = sum[7] ? 5'(8'd0 - sum) : sum[4:0];
               state_in = tca_pkg::EX_NORM;
            end else begin
               res_in   = sum;
               wrap_in  = 1'b0;
               state_in = tca_pkg::EX_DONE;
            end
         end
         tca_pkg::EX_NORM: begin
            // one normalization step per cycle
            if (mag_ff >= 5'd16) begin
               mag_in = mag_ff >> 1;
               exp_in = exp_ff + 4'd1;
            end else if ((mag_ff != 5'd0) && (mag_ff < 5'd8) && (exp_ff != 4'd0)) begin
               mag_in = mag_ff << 1;
               exp_in = exp_ff - 4'd1;
            end else begin
               res_in   = {neg_ff, exp_ff[2:0], mag_ff[3:0]};
               wrap_in  = exp_ff[3];
               state_in = tca_pkg::EX_DONE;
            end
         end
         tca_pkg::EX_DONE: begin
            ex_rsp.done = 1'b1;
            state_in    = tca_pkg::EX_IDLE;
         end
         default: begin
            state_in = tca_pkg::EX_IDLE;
         end
      endcase
   end

endmodule

>>> hdl/tiny_cpu_alu_int_and_float_add.sv
// Tiny CPU ALU: 16 x 8-bit register file, integer add, 8-bit float add, load.
// A load goes straight to write-back; an add reads operand A, then operand B, then
// runs the unit and writes back; float normalization does one shift per cycle, up to three.
// One transaction at a time, set by the single read port and the iterative unit: a new
// one is accepted only once the last is written back, which waits on any result stall.
// Synchronous reset clears the register file to zero through per-entry valid bits.
`timescale 1ns / 1ps

module tiny_cpu_alu_int_and_float_add (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_mode,
   input  logic [3:0]  req_dest_reg,
   input  logic [3:0]  req_src_a,
   input  logic [3:0]  req_src_b,
   input  logic [7:0]  req_load_value,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [3:0]  rsp_written_reg,
   output logic [7:0]  rsp_written_value,
   output logic        rsp_exp_wrapped
);

   tca_pkg::ctl_state_type state_ff, state_in;

   logic [tca_pkg::RF_ADDR_W-1:0] dest_ff, dest_in;
   logic [tca_pkg::RF_ADDR_W-1:0] src_a_ff, src_a_in;
   logic [tca_pkg::RF_ADDR_W-1:0] src_b_ff, src_b_in;
   logic                          is_float_ff, is_float_in;
   logic [tca_pkg::DATA_W-1:0]    val_ff, val_in;
   logic                          wrap_ff, wrap_in;
   logic [tca_pkg::DATA_W-1:0]    op_a_ff, op_a_in;
   logic [tca_pkg::RF_DEPTH-1:0]  rf_valid_ff, rf_valid_in;
   logic                          rd_hit_ff, rd_hit_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [tca_pkg::RF_ADDR_W-1:0] rsp_reg_ff, rsp_reg_in;
   logic [tca_pkg::DATA_W-1:0]    rsp_value_ff, rsp_value_in;
   logic                          rsp_wrap_ff, rsp_wrap_in;

   logic                          wr_en;
   logic [tca_pkg::RF_ADDR_W-1:0] rd_addr;
   logic [tca_pkg::DATA_W-1:0]    rd_data;
   logic [tca_pkg::DATA_W-1:0]    rd_word;

   tca_pkg::exec_req_type ex_req;
   tca_pkg::exec_rsp_type ex_rsp;

   // register file storage
   tca_ram #(
      .WIDTH (tca_pkg::DATA_W),
      .DEPTH (tca_pkg::RF_DEPTH)
   ) u_rf (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (dest_ff),
      .wr_data (val_ff),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // shared arithmetic unit
   tca_exec u_exec (
      .clock  (clock),
      .reset  (reset),
      .ex_req (ex_req),
      .ex_rsp (ex_rsp)
   );

   // entries never written since reset read as zero
   assign rd_word   = rd_hit_ff ? rd_data : '0;
   assign rd_hit_in = rf_valid_ff[rd_addr];

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tca_pkg::ST_IDLE;
         rf_valid_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rf_valid_ff  <= rf_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      dest_ff      <= dest_in;
      src_a_ff     <= src_a_in;
      src_b_ff     <= src_b_in;
      is_float_ff  <= is_float_in;
      val_ff       <= val_in;
      wrap_ff      <= wrap_in;
      op_a_ff      <= op_a_in;
      rd_hit_ff    <= rd_hit_in;
      rsp_reg_ff   <= rsp_reg_in;
      rsp_value_ff <= rsp_value_in;
      rsp_wrap_ff  <= rsp_wrap_in;
   end

   // sequence one transaction: read operands, run the unit, write back
   always_comb begin
      state_in     = state_ff;
      dest_in      = dest_ff;
      src_a_in     = src_a_ff;
      src_b_in     = src_b_ff;
      is_float_in  = is_float_ff;
      val_in       = val_ff;
      wrap_in      = wrap_ff;
      op_a_in      = op_a_ff;
      rf_valid_in  = rf_valid_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      rsp_reg_in   = rsp_reg_ff;
      rsp_value_in = rsp_value_ff;
      rsp_wrap_in  = rsp_wrap_ff;
      req_stall    = 1'b1;
      wr_en        = 1'b0;
      rd_addr      = src_a_ff;
      ex_req.start    = 1'b0;
      ex_req.is_float = is_float_ff;
      ex_req.op_a     = op_a_ff;
      ex_req.op_b     = rd_word;

      case (state_ff)
         tca_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               dest_in     = req_dest_reg;
               src_a_in    = req_src_a;
               src_b_in    = req_src_b;
               is_float_in = (req_mode == tca_pkg::MODE_FLOAT);
               case (req_mode)
                  tca_pkg::MODE_INT,
                  tca_pkg::MODE_FLOAT: begin
                     state_in = tca_pkg::ST_RD_A;
                  end
                  tca_pkg::MODE_LOAD: begin
                     val_in   = req_load_value;
                     wrap_in  = 1'b0;
                     state_in = tca_pkg::ST_WRITE;
                  end
                  default: begin
                     // undefined mode: drop the transaction
                     state_in = tca_pkg::ST_IDLE;
                  end
               endcase
            end
         end
         tca_pkg::ST_RD_A: begin
            rd_addr  = src_a_ff;
            state_in = tca_pkg::ST_RD_B;
         end
         tca_pkg::ST_RD_B: begin
            rd_addr  = src_b_ff;
            op_a_in  = rd_word;
            state_in = tca_pkg::ST_EXEC;
         end
         tca_pkg::ST_EXEC: begin
            ex_req.start = 1'b1;
            state_in     = tca_pkg::ST_WAIT;
         end
         tca_pkg::ST_WAIT: begin
            if (ex_rsp.done) begin
               val_in   = ex_rsp.value;
               wrap_in  = ex_rsp.wrapped;
               state_in = tca_pkg::ST_WRITE;
            end
         end
         tca_pkg::ST_WRITE: begin
            // write back once the output register is free
            if (!rsp_valid_ff || !rsp_stall) begin
               wr_en                = 1'b1;
               rf_valid_in[dest_ff] = 1'b1;
               rsp_valid_in         = 1'b1;
               rsp_reg_in           = dest_ff;
               rsp_value_in         = val_ff;
               rsp_wrap_in          = wrap_ff;
               state_in             = tca_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = tca_pkg::ST_IDLE;
         end
      endcase
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_written_reg   = rsp_reg_ff;
   assign rsp_written_value = rsp_value_ff;
   assign rsp_exp_wrapped   = rsp_wrap_ff;

endmodule
